>>> src/rkfp_pkg.sv
`timescale 1ns / 1ps

package rkfp_pkg;

    // Channel layout of the packed word
    localparam int NUM_CHANNELS  = 4;
    localparam int CHANNEL_SLOTS = 4;
    localparam int LANE_BITS     = 2;
    localparam int CH_BITS       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BYTE_BITS     = 8;
    localparam int WORD_BITS     = CHANNEL_SLOTS * BYTE_BITS;

    // Sample and level widths
    localparam int SAMPLE_BITS   = 12;
    localparam int ALPHA_BITS    = 16;
    localparam int SCALE_BITS    = 10;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int FPROD_BITS    = ALPHA_BITS + 1 + DIFF_BITS;
    localparam int SPROD_BITS    = SAMPLE_BITS + SCALE_BITS;
    localparam int QUO_HI_BITS   = SPROD_BITS - SAMPLE_BITS;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [BYTE_BITS-1:0]   BYTE_MAX   = {BYTE_BITS{1'b1}};

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = ALPHA_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FILTER_ALPHA = 1'b0,
        REG_SCALE_TOP    = 1'b1
    } cfg_reg_t;

    localparam logic [ALPHA_BITS-1:0] FILTER_ALPHA_RESET = 16'd64225;
    localparam logic [SCALE_BITS-1:0] SCALE_TOP_RESET    = 10'd260;

    // Controller to datapath
    typedef struct packed {
        logic               load;    // capture samples, clear word
        logic               filt;    // alpha * (old - sample)
        logic               scale;   // new level, level * scale_top
        logic               pack;    // divide, saturate, place byte
        logic               finish;  // compare with previous word, emit
        logic [CH_BITS-1:0] ch;
    } rkfp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } rkfp_status_t;

endpackage

>>> src/rgba_knob_filter_pack_unit.sv
`timescale 1ns / 1ps

// Four-channel knob smoother and color packer. Each input transfer carries
// one 12-bit sample for red, green, blue and alpha. Every channel keeps a
// first-order low-pass level, level' = floor((a*level + (65536-a)*sample)/65536)
// with a = filter_alpha (Q0.16, reset 64225, about 0.98), scales it as
// floor(level*scale_top/4095) (scale_top reset 260) and clamps the byte at 255.
// The bytes are packed red in bits 31:24 down to alpha in bits 7:0. A word
// goes out only when the previous word was nonzero and differs from the new
// one; the previous word is updated on every item. Config writes: index 0 is
// filter_alpha, index 1 is scale_top; cfg_ready is always high, and writes
// belong in idle periods. Each item is accepted, then filtered, scaled and
// packed channel by channel through the two multipliers shared by all
// channels, then compared and emitted; only then is the next item taken.
// The result sits in an output register, so a new item is taken while a word
// still waits; emit stalls only while the previous word is not transferred.
module rgba_knob_filter_pack_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rkfp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rkfp_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_red,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_green,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_blue,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_alpha,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rkfp_pkg::WORD_BITS-1:0]       color_word
);

    rkfp_pkg::rkfp_cmd_t    cmd;
    rkfp_pkg::rkfp_status_t status;

    // registers are plain flops; a write is always accepted
    assign cfg_ready = 1'b1;

    // sequencer: walks the channels, at most one multiply per step
    rkfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // filter levels, shared multipliers, divider fixup, packing, output reg
    rkfp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .sample_alpha (sample_alpha),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .color_word   (color_word)
    );

    // the block is busy right after taking an item
    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("in_ready high the cycle after an input transfer");

    // a new result only comes from the emit step
    a_result_from_emit : assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish)
    ) else $error("out_valid rose without an emit step");

    // emit never overwrites a word still waiting
    a_emit_when_free : assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready)
    ) else $error("emit step while the output register is occupied");

endmodule

>>> src/rkfp_ctrl.sv
`timescale 1ns / 1ps

module rkfp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rkfp_pkg::rkfp_status_t status,
    output rkfp_pkg::rkfp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_SCALE,
        ST_PACK,
        ST_FINISH
    } state_t;

    localparam logic [rkfp_pkg::CH_BITS-1:0] LAST_CH =
        rkfp_pkg::CH_BITS'(rkfp_pkg::NUM_CHANNELS - 1);

    state_t                        state_reg, state_next;
    logic [rkfp_pkg::CH_BITS-1:0]  ch_reg, ch_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FILT;
                    ch_next    = '0;
                end
            end
            ST_FILT:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_PACK;
            ST_PACK:
            begin
                if (ch_reg == LAST_CH)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_FILT;
                    ch_next    = ch_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take a word
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.filt   = (state_reg == ST_FILT);
        cmd.scale  = (state_reg == ST_SCALE);
        cmd.pack   = (state_reg == ST_PACK);
        cmd.finish = (state_reg == ST_FINISH) && status.out_free;
        cmd.ch     = ch_reg;
    end

endmodule

>>> src/rkfp_datapath.sv
`timescale 1ns / 1ps

module rkfp_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rkfp_pkg::rkfp_cmd_t                  cmd,
    output rkfp_pkg::rkfp_status_t               status,
    input  logic                                 cfg_write,
    input  logic [rkfp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rkfp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_red,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_green,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_blue,
    input  logic [rkfp_pkg::SAMPLE_BITS-1:0]     sample_alpha,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rkfp_pkg::WORD_BITS-1:0]       color_word
);

    localparam int SB = rkfp_pkg::SAMPLE_BITS;
    localparam int NC = rkfp_pkg::NUM_CHANNELS;

    logic [rkfp_pkg::ALPHA_BITS-1:0] alpha_reg;
    logic [rkfp_pkg::SCALE_BITS-1:0] scale_reg;

    logic [SB-1:0] sample_reg [NC];
    logic [SB-1:0] level_reg  [NC];

    logic signed [rkfp_pkg::FPROD_BITS-1:0] fprod_reg;
    logic        [rkfp_pkg::SPROD_BITS-1:0] sprod_reg;

    logic [rkfp_pkg::CHANNEL_SLOTS-1:0][rkfp_pkg::BYTE_BITS-1:0] word_reg;
    logic [rkfp_pkg::WORD_BITS-1:0] prev_reg;
    logic [rkfp_pkg::WORD_BITS-1:0] out_word_reg;
    logic                           out_valid_reg;

    logic [SB-1:0]                           cur_sample;
    logic [SB-1:0]                           cur_level;
    logic signed [rkfp_pkg::DIFF_BITS-1:0]   diff;
    logic signed [rkfp_pkg::FPROD_BITS-1:0]  fprod;
    logic signed [SB+1:0]                    fstep;
    logic        [SB+1:0]                    lvl_sum;
    logic        [SB-1:0]                    new_level;
    logic        [rkfp_pkg::QUO_HI_BITS-1:0] quo_lo;
    logic        [SB-1:0]                    rem_lo;
    logic        [SB:0]                      rem_adj;
    logic        [rkfp_pkg::QUO_HI_BITS:0]   quo;
    logic        [rkfp_pkg::BYTE_BITS-1:0]   byte_val;
    logic        [rkfp_pkg::LANE_BITS-1:0]   lane;
    logic        [rkfp_pkg::WORD_BITS-1:0]   word_flat;
    logic                                    fire;

    // Filter step: level' = sample + floor(alpha * (old - sample) / 2^16)
    assign cur_sample = sample_reg[cmd.ch];
    assign cur_level  = level_reg[cmd.ch];
    assign diff  = $signed({1'b0, cur_level}) - $signed({1'b0, cur_sample});
    assign fprod = $signed({1'b0, alpha_reg}) * diff;

    assign fstep     = fprod_reg[rkfp_pkg::FPROD_BITS-1:rkfp_pkg::ALPHA_BITS];
    assign lvl_sum   = (SB+2)'({2'b00, cur_sample}) + (SB+2)'(fstep);
    assign new_level = lvl_sum[SB-1:0];

    // Divide by 2^SB-1: quotient is p>>SB, plus one when rem + that >= 2^SB-1
    assign quo_lo  = sprod_reg[rkfp_pkg::SPROD_BITS-1:SB];
    assign rem_lo  = sprod_reg[SB-1:0];
    assign rem_adj = {1'b0, rem_lo} + (SB+1)'(quo_lo);
    assign quo     = {1'b0, quo_lo}
                   + (rkfp_pkg::QUO_HI_BITS+1)'(rem_adj >= {1'b0, rkfp_pkg::FULL_SCALE});
    assign byte_val = (quo > (rkfp_pkg::QUO_HI_BITS+1)'(rkfp_pkg::BYTE_MAX))
                    ? rkfp_pkg::BYTE_MAX : quo[rkfp_pkg::BYTE_BITS-1:0];

    // red lands in the top byte
    assign lane = rkfp_pkg::LANE_BITS'(rkfp_pkg::CHANNEL_SLOTS - 1)
                - rkfp_pkg::LANE_BITS'(cmd.ch);

    assign word_flat = word_reg;
    assign fire      = (prev_reg != '0) && (prev_reg != word_flat);

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign color_word      = out_word_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= rkfp_pkg::FILTER_ALPHA_RESET;
            scale_reg <= rkfp_pkg::SCALE_TOP_RESET;
        end
        else if (cfg_write)
        begin
            case (rkfp_pkg::cfg_reg_t'(cfg_index))
                rkfp_pkg::REG_FILTER_ALPHA: alpha_reg <= cfg_data;
                rkfp_pkg::REG_SCALE_TOP:
                    scale_reg <= cfg_data[rkfp_pkg::SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg[0] <= sample_red;
            if (NC > 1) sample_reg[(NC > 1) ? 1 : 0] <= sample_green;
            if (NC > 2) sample_reg[(NC > 2) ? 2 : 0] <= sample_blue;
            if (NC > 3) sample_reg[(NC > 3) ? 3 : 0] <= sample_alpha;
        end
        if (cmd.filt)
        begin
            fprod_reg <= fprod;
        end
        if (cmd.scale)
        begin
            sprod_reg <= new_level * scale_reg;
        end
        if (cmd.finish && fire)
        begin
            out_word_reg <= word_flat;
        end
    end

    // filter state, packed word, previous word, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                level_reg[i] <= '0;
            end
            word_reg      <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scale)
            begin
                level_reg[cmd.ch] <= new_level;
            end
            if (cmd.load)
            begin
                word_reg <= '0;
            end
            else if (cmd.pack)
            begin
                word_reg[lane] <= byte_val;
            end
            if (cmd.finish)
            begin
                prev_reg <= word_flat;
            end
            if (cmd.finish && fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> sim/rgba_knob_filter_pack_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the four-channel knob smoother / color packer.
module rgba_knob_filter_pack_unit_tb;

    import rkfp_pkg::*;

    // Red is element 0, alpha element 3
    typedef logic [0:3][SAMPLE_BITS-1:0] quad_t;
    typedef logic [WORD_BITS-1:0]        word_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
    // CHK_MODEL: expectation from the predictor
    // CHK_SILENT: typed in, no word may come out
    // CHK_WORD: typed in, exactly this word comes out
    typedef enum {CHK_MODEL, CHK_SILENT, CHK_WORD} row_check_t;

    typedef struct {
        row_kind_t           kind;
        cfg_reg_t            sel;
        logic [ALPHA_BITS-1:0] data;
        quad_t               smp;
        row_check_t          chk;
        word_t               word;
    } stim_row_t;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_BITS-1:0] sample_red;
    logic [SAMPLE_BITS-1:0] sample_green;
    logic [SAMPLE_BITS-1:0] sample_blue;
    logic [SAMPLE_BITS-1:0] sample_alpha;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    word_t                 color_word;

    // Predictor state: register copies, per-channel levels, last packed word
    logic [ALPHA_BITS-1:0]  alpha_w;
    logic [SCALE_BITS-1:0]  scale_w;
    logic [SAMPLE_BITS-1:0] level_q [4];
    word_t                  prev_word;

    word_t     pending_words [$];
    stim_row_t directed_rows [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        out_stall = 0;
    bit        out_calm = 1'b0;
    bit        in_calm = 1'b0;
    word_t     exp_word;
    quad_t     last_smp;

    rgba_knob_filter_pack_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .sample_alpha (sample_alpha),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .color_word   (color_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One step of the smoother: new level per channel, scale and clamp,
    // pack red-high. Returns 1 when a word is due (old word nonzero and
    // different from the new one). The old word is replaced either way.
    function automatic bit smooth_and_pack(input quad_t smp, output word_t word);
        logic [63:0]            acc;
        logic [63:0]            scaled;
        logic [SAMPLE_BITS-1:0] lvl;
        bit                     fire;
        word = '0;
        for (int ch = 0; ch < NUM_CHANNELS && ch < 4; ch++)
        begin
            acc = 64'(alpha_w) * 64'(level_q[ch])
                + ((64'd1 << ALPHA_BITS) - 64'(alpha_w)) * 64'(smp[ch]);
            lvl = acc[ALPHA_BITS +: SAMPLE_BITS];   // floor(acc / 65536)
            level_q[ch] = lvl;
            scaled = (64'(lvl) * 64'(scale_w)) / 64'(FULL_SCALE);
            word[WORD_BITS-1-BYTE_BITS*ch -: BYTE_BITS] =
                (scaled > 64'(BYTE_MAX)) ? BYTE_MAX : scaled[BYTE_BITS-1:0];
        end
        fire = (prev_word != '0) && (prev_word != word);
        prev_word = word;
        return fire;
    endfunction

    // Directed table builders
    task automatic row_item(input logic [SAMPLE_BITS-1:0] r, g, b, a,
                            input row_check_t chk, input word_t word);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.sel  = REG_FILTER_ALPHA;
        row.data = '0;
        row.smp  = {r, g, b, a};
        row.chk  = chk;
        row.word = word;
        directed_rows.push_back(row);
    endtask

    task automatic row_cfg(input cfg_reg_t sel, input logic [ALPHA_BITS-1:0] data);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.sel  = sel;
        row.data = data;
        row.smp  = '0;
        row.chk  = CHK_MODEL;
        row.word = '0;
        directed_rows.push_back(row);
    endtask

    // Hold valid low for a gap of length n before the next item; n == 0 keeps it high
    task automatic hold_off_input(input int n);
        if (n > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Present one sample set, wait for the transfer, record what is due
    task automatic push_samples(input quad_t smp, input row_check_t chk,
                                input word_t typed_word);
        word_t w;
        bit    fire;
        @(negedge clk);
        in_valid     <= 1'b1;
        sample_red   <= smp[0];
        sample_green <= smp[1];
        sample_blue  <= smp[2];
        sample_alpha <= smp[3];
        do
            @(posedge clk);
        while (!in_ready);
        fire = smooth_and_pack(smp, w);
        case (chk)
            CHK_MODEL:  if (fire) pending_words.push_back(w);
            CHK_WORD:   pending_words.push_back(typed_word);
            CHK_SILENT: ;
            default:    ;
        endcase
        last_smp = smp;
    endtask

    // Register writes happen only with the block drained and quiet
    task automatic write_register(input cfg_reg_t sel,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk) in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        // An item with no word may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            REG_FILTER_ALPHA: alpha_w = data[ALPHA_BITS-1:0];
            REG_SCALE_TOP:    scale_w = data[SCALE_BITS-1:0];
            default:          ;
        endcase
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Knob-like samples: repeats, rail values, small moves and wild jumps
    function automatic quad_t random_samples(input quad_t last);
        quad_t smp;
        int    r;
        int    v;
        r = $urandom_range(0, 99);
        for (int ch = 0; ch < 4; ch++)
        begin
            if (r < 10)
                smp[ch] = last[ch];
            else if (r < 30)
                smp[ch] = $urandom_range(0, 1) ? FULL_SCALE : '0;
            else if (r < 70)
            begin
                v = int'(last[ch]) + $urandom_range(0, 128) - 64;
                v = (v < 0) ? 0 : ((v > int'(FULL_SCALE)) ? int'(FULL_SCALE) : v);
                smp[ch] = v[SAMPLE_BITS-1:0];
            end
            else
                smp[ch] = SAMPLE_BITS'($urandom_range(0, int'(FULL_SCALE)));
        end
        return smp;
    endfunction

    // Output side: ready with random stalls, calm stretches now and then
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            out_calm <= !out_calm;
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall <= out_calm ? 0 : pick_gap();
        end
    end

    // Result checker: every output transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("color_word: no result expected, got %h", color_word);
                mismatches++;
            end
            else
            begin
                exp_word = pending_words.pop_front();
                if (color_word !== exp_word)
                begin
                    $error("color_word: expected %h, actual %h", exp_word, color_word);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int    gap;
        quad_t smp;
        int    r;
        logic [ALPHA_BITS-1:0] alpha_pick;
        logic [SCALE_BITS-1:0] scale_pick;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_FILTER_ALPHA;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample_red   = '0;
        sample_green = '0;
        sample_blue  = '0;
        sample_alpha = '0;
        alpha_w      = FILTER_ALPHA_RESET;
        scale_w      = SCALE_TOP_RESET;
        prev_word    = '0;
        last_smp     = '0;
        foreach (level_q[i])
            level_q[i] = '0;

        // Directed table. Reset defaults first: levels rise to 81, byte 5,
        // but the old word is zero so nothing comes out.
        row_item(12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_SILENT, '0);
        // Zero weight: level follows the sample; scale 255 maps full to 255
        row_cfg(REG_FILTER_ALPHA, 16'd0);
        row_cfg(REG_SCALE_TOP, 16'd255);
        row_item(12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_WORD, 32'hFFFF_FFFF);
        // Same word again: silent
        row_item(12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_SILENT, '0);
        // Falling to zero still reports, since the old word was nonzero
        row_item(12'd0, 12'd0, 12'd0, 12'd0, CHK_WORD, 32'h0000_0000);
        // Old word zero: silent even though the word changes
        row_item(12'd4095, 12'd0, 12'd4095, 12'd0, CHK_SILENT, '0);
        row_item(12'd0, 12'd4095, 12'd0, 12'd4095, CHK_WORD, 32'h00FF_00FF);
        // Large scale clamps at 255
        row_cfg(REG_SCALE_TOP, 16'd1023);
        row_item(12'd4095, 12'd2048, 12'd1024, 12'd0, CHK_WORD, 32'hFFFF_FF00);
        // Upper data bits are dropped: 0xFC00 gives scale zero, all bytes 0
        row_cfg(REG_SCALE_TOP, 16'hFC00);
        row_item(12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_WORD, 32'h0000_0000);
        row_item(12'd123, 12'd456, 12'd789, 12'd4000, CHK_SILENT, '0);
        // Scale one: only a full-scale level gives byte 1
        row_cfg(REG_SCALE_TOP, 16'd1);
        row_item(12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_SILENT, '0);
        row_item(12'd4094, 12'd4095, 12'd4095, 12'd4095, CHK_WORD, 32'h0001_0101);
        // Heaviest weight: levels creep, truncation may hold them still
        row_cfg(REG_FILTER_ALPHA, 16'hFFFF);
        row_cfg(REG_SCALE_TOP, 16'd1023);
        row_item(12'd0, 12'd0, 12'd0, 12'd0, CHK_MODEL, '0);
        row_item(12'd0, 12'd0, 12'd0, 12'd0, CHK_MODEL, '0);
        row_item(12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_MODEL, '0);
        // Back to the reset settings with mixed samples
        row_cfg(REG_FILTER_ALPHA, FILTER_ALPHA_RESET);
        row_cfg(REG_SCALE_TOP, 16'(SCALE_TOP_RESET));
        row_item(12'd2000, 12'd1000, 12'd3000, 12'd500, CHK_MODEL, '0);
        row_item(12'd4095, 12'd4095, 12'd0, 12'd0, CHK_MODEL, '0);

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_register(directed_rows[i].sel, directed_rows[i].data);
            else
            begin
                hold_off_input(pick_gap());
                push_samples(directed_rows[i].smp, directed_rows[i].chk,
                             directed_rows[i].word);
            end
        end

        // Random phases, each with fresh register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                alpha_pick = '0;
            else if (r < 35)
                alpha_pick = '1;
            else if (r < 55)
                alpha_pick = ALPHA_BITS'($urandom_range(60000, 65535));
            else
                alpha_pick = ALPHA_BITS'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 10)
                scale_pick = 10'd1023;
            else if (r < 18)
                scale_pick = 10'd0;
            else if (r < 25)
                scale_pick = 10'd1;
            else
                scale_pick = SCALE_BITS'($urandom_range(1, 1023));
            write_register(REG_FILTER_ALPHA, alpha_pick);
            // random junk in the unused upper data bits
            write_register(REG_SCALE_TOP, {6'($urandom_range(0, 63)), scale_pick});

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    in_calm = !in_calm;
                gap = in_calm ? 0 : pick_gap();
                hold_off_input(gap);
                smp = random_samples(last_smp);
                push_samples(smp, CHK_MODEL, '0);
            end
        end

        @(negedge clk) in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
